[hdl/rmgp_pkg.sv]
// shared types and constants for the resource element mask gather planner
package rmgp_pkg;

    localparam int MAX_ENTRIES  = 65536;
    localparam int MAX_PRBS     = 275;
    localparam int SC_PER_PRB   = 12;
    localparam int SLOT_SYMBOLS = 14;
    localparam int QDEPTH       = 4;
    localparam int QAW          = $clog2(QDEPTH);
    localparam int QCW          = $clog2(QDEPTH + 1);
    localparam int CFG_DW       = 14;
    localparam int CFG_AW       = 2;

    typedef enum logic [CFG_AW-1:0] {
        CFG_START_SYMBOL     = 2'd0,
        CFG_DATA_RE_MASK     = 2'd1,
        CFG_DMRS_RE_MASK     = 2'd2,
        CFG_DMRS_SYMBOL_MASK = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic [3:0] symbol_offset;
        logic [8:0] prb;
        logic       prb_allocated;
        logic       plan_start;
        logic       symbol_start;
        logic       symbol_end;
    } t_in_item;

    typedef struct packed {
        logic        entry_valid;
        logic [11:0] subcarrier;
        logic [11:0] destination;
        logic [15:0] entry_index;
        logic [3:0]  grid_symbol;
        logic        run_end;
        logic [15:0] run_base;
        logic [11:0] run_count;
        logic        overflow;
        logic        last;
    } t_out_item;

    // classified item handed from front to back
    typedef struct packed {
        logic [11:0] mask;
        logic [11:0] base_sc;
        logic [3:0]  grid_symbol;
        logic        plan_start;
        logic        symbol_start;
        logic        symbol_end;
    } t_task;

endpackage

[hdl/rmgp_front.sv]
// front end: configuration registers, input handshake and mask selection
module rmgp_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [1:0]             i_cfg_addr,
    input  logic [13:0]            i_cfg_data,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  rmgp_pkg::t_in_item     i_in_item,
    input  logic                   i_q_full,
    output logic                   o_q_push,
    output rmgp_pkg::t_task        o_q_task
);
    import rmgp_pkg::*;

    logic [3:0]  r_start_symbol;
    logic [11:0] r_data_re_mask;
    logic [11:0] r_dmrs_re_mask;
    logic [13:0] r_dmrs_symbol_mask;

    logic [4:0]  sym_sum;
    logic        dmrs_sym;
    logic        prb_ok;
    logic [11:0] prb_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_symbol     <= '0;
            r_data_re_mask     <= 12'hFFF;
            r_dmrs_re_mask     <= '0;
            r_dmrs_symbol_mask <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_addr))
                CFG_START_SYMBOL:     r_start_symbol     <= i_cfg_data[3:0];
                CFG_DATA_RE_MASK:     r_data_re_mask     <= i_cfg_data[11:0];
                CFG_DMRS_RE_MASK:     r_dmrs_re_mask     <= i_cfg_data[11:0];
                CFG_DMRS_SYMBOL_MASK: r_dmrs_symbol_mask <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        sym_sum  = {1'b0, r_start_symbol} + {1'b0, i_in_item.symbol_offset};
        // symbols past the slot never carry dm-rs
        dmrs_sym = (sym_sum < 5'(SLOT_SYMBOLS)) && r_dmrs_symbol_mask[sym_sum[3:0]];
        prb_ok   = i_in_item.prb_allocated && (i_in_item.prb < 9'(MAX_PRBS));
        prb_ext  = {3'b0, i_in_item.prb};

        o_q_task.mask         = prb_ok ? (dmrs_sym ? r_dmrs_re_mask : r_data_re_mask) : '0;
        o_q_task.base_sc      = (prb_ext << 3) + (prb_ext << 2);
        o_q_task.grid_symbol  = sym_sum[3:0];
        o_q_task.plan_start   = i_in_item.plan_start;
        o_q_task.symbol_start = i_in_item.symbol_start;
        o_q_task.symbol_end   = i_in_item.symbol_end;
    end

    assign o_in_stall = i_q_full;
    assign o_q_push   = i_in_valid && !i_q_full;

endmodule

[hdl/rmgp_fifo.sv]
// short task queue between front and back
module rmgp_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  rmgp_pkg::t_task   i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_empty,
    output rmgp_pkg::t_task   o_data
);
    import rmgp_pkg::*;

    t_task            r_mem [QDEPTH];
    logic [QAW-1:0]   r_wptr;
    logic [QAW-1:0]   r_rptr;
    logic [QCW-1:0]   r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == QCW'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == QAW'(QDEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == QAW'(QDEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[hdl/rmgp_back.sv]
// back end: walks masks one subcarrier per unstalled cycle, owns the counters
module rmgp_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_empty,
    input  rmgp_pkg::t_task      i_q_task,
    output logic                 o_q_pop,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output rmgp_pkg::t_out_item  o_out_item
);
    import rmgp_pkg::*;

    localparam logic [16:0] ENTRY_LIMIT = 17'(MAX_ENTRIES);

    logic        r_act;
    t_task       r_task;
    logic [16:0] r_entry_count;
    logic [11:0] r_dest_count;
    logic [16:0] r_run_start;
    logic        r_out_valid;
    t_out_item   r_out;

    t_task       n_task;
    t_out_item   n_out;
    logic [16:0] n_entry_count;
    logic [11:0] n_dest_count;
    logic [16:0] n_run_start;

    logic [16:0] ec;
    logic [16:0] rs;
    logic [11:0] dc;
    logic [11:0] lowbit;
    logic [11:0] rem;
    logic [3:0]  bit_idx;
    logic        has_bit;
    logic        full;
    logic        emit;
    logic        final_step;
    logic        out_free;
    logic        fire;
    logic        pop;

    always_comb begin
        // start-of-plan and start-of-symbol take effect on the task's first step
        ec = r_task.plan_start ? '0 : r_entry_count;
        rs = r_task.plan_start ? '0 : r_run_start;
        if (r_task.symbol_start) begin
            rs = ec;
        end
        dc = r_task.symbol_start ? '0 : r_dest_count;

        lowbit  = r_task.mask & (~r_task.mask + 12'd1);
        rem     = r_task.mask & ~lowbit;
        has_bit = |r_task.mask;
        bit_idx = '0;
        for (int k = 0; k < SC_PER_PRB; k++) begin
            if (lowbit[k]) begin
                bit_idx = bit_idx | 4'(k);
            end
        end
        full       = (ec >= ENTRY_LIMIT);
        emit       = has_bit || r_task.symbol_end;
        final_step = !has_bit || (rem == '0);

        n_entry_count = ec;
        n_dest_count  = dc;
        n_run_start   = rs;
        if (has_bit && !full) begin
            n_entry_count = ec + 17'd1;
            n_dest_count  = dc + 12'd1;
        end

        n_out             = '0;
        n_out.grid_symbol = r_task.grid_symbol;
        if (has_bit) begin
            n_out.entry_valid = !full;
            n_out.subcarrier  = r_task.base_sc + {8'b0, bit_idx};
            n_out.destination = dc;
            n_out.entry_index = full ? '0 : ec[15:0];
            n_out.overflow    = full;
        end
        if (final_step && r_task.symbol_end) begin
            n_out.run_end   = 1'b1;
            n_out.run_base  = rs[15:0];
            n_out.run_count = n_dest_count;
        end
        n_out.last = final_step;

        n_task              = r_task;
        n_task.mask         = rem;
        n_task.plan_start   = 1'b0;
        n_task.symbol_start = 1'b0;
    end

    assign out_free = !r_out_valid || !i_out_stall;
    assign fire     = r_act && (!emit || out_free);
    assign pop      = !i_q_empty && (!r_act || (fire && final_step));
    assign o_q_pop  = pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act         <= 1'b0;
            r_entry_count <= '0;
            r_dest_count  <= '0;
            r_run_start   <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (fire) begin
                r_entry_count <= n_entry_count;
                r_dest_count  <= n_dest_count;
                r_run_start   <= n_run_start;
            end
            if (pop) begin
                r_act <= 1'b1;
            end else if (fire && final_step) begin
                r_act <= 1'b0;
            end
            if (fire && emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_task <= i_q_task;
        end else if (fire) begin
            r_task <= n_task;
        end
        if (fire && emit) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

[hdl/re_mask_gather_plan.sv]
// top level of the resource element mask gather planner
// Each input item is one PRB position of a symbol's ascending walk. The front end
// picks the 12-bit subcarrier mask (dm-rs or data, by the grid symbol's bit) and
// queues the classified item in a four-deep queue, so a new item is taken in any
// cycle the queue has room, even while results wait at the output. The back end
// emits one result per cycle while the output is not stalled: one per set mask
// bit, plus a lone run report when a symbol ends on an item with no entries. An
// item therefore yields at most 12 results; that single result per cycle on the
// output register is what sets the sustained rate. Configuration is written
// through a plain write port (index 0 start symbol of the hop, 1 data_re_mask,
// 2 dmrs_re_mask, 3 dmrs_symbol_mask) and should only change while idle.
module re_mask_gather_plan (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_addr,
    input  logic [13:0]          i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  rmgp_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output rmgp_pkg::t_out_item  o_out_item
);
    import rmgp_pkg::*;

    // front to queue
    logic  q_push;
    logic  q_full;
    t_task q_wdata;
    // queue to back
    logic  q_pop;
    logic  q_empty;
    t_task q_rdata;

    rmgp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_task   (q_wdata)
    );

    // decouples mask selection from the per-subcarrier walk
    rmgp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_rdata)
    );

    // counters live here: entry count, destination count, run start
    rmgp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_q_task    (q_rdata),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

[hdl/rmgp_checker.sv]
// port-level checks for the gather planner, bound to the top level
module rmgp_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input rmgp_pkg::t_out_item  o_out_item
);
    import rmgp_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("result changed while stalled");

    // a dropped entry is never also a written one
    a_ovf_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_item.overflow && o_out_item.entry_valid))
        else $error("overflow together with entry_valid");

    // the run report rides on the item's final result
    a_run_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.run_end |-> o_out_item.last)
        else $error("run_end without last");

    // run fields stay clear outside a run report
    a_run_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.run_end |->
            (o_out_item.run_base == '0) && (o_out_item.run_count == '0))
        else $error("run fields set without run_end");

    // subcarriers stay inside the carrier grid
    a_sc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.subcarrier < 12'(MAX_PRBS * SC_PER_PRB)))
        else $error("subcarrier out of grid");

endmodule

bind re_mask_gather_plan rmgp_checker u_rmgp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);
